[hdl/vertex_light_fog_shader_defines.svh]
// Assertion macros for the vertex shader block.
`ifndef VERTEX_LIGHT_FOG_SHADER_DEFINES_SVH
`define VERTEX_LIGHT_FOG_SHADER_DEFINES_SVH

// Same-cycle implication.
`define VLFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VLFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/vlfs_pkg.sv]
`default_nettype none

package vlfs_pkg;

    typedef enum logic [2:0] {
        REG_AMBIENT   = 3'd0,
        REG_FOG_START = 3'd1,
        REG_DIR0      = 3'd2,
        REG_DIR1      = 3'd3,
        REG_DIR2      = 3'd4,
        REG_COL_R     = 3'd5,
        REG_COL_G     = 3'd6,
        REG_COL_B     = 3'd7
    } t_reg_idx;

    localparam int unsigned ADDR_W = 6;
    localparam int unsigned DATA_W = 64;

    // vertex commands
    localparam logic CMD_PRELIT = 1'b0;
    localparam logic CMD_LIT    = 1'b1;

    localparam logic [12:0] PRELIT_MAX      = 13'h1FFF;
    localparam logic [7:0]  SHADE_FULL      = 8'd255;
    localparam logic [11:0] FOG_ONE         = 12'd2048;
    localparam logic [16:0] FOG_START_RESET = 17'h1FFFF;
    localparam logic [7:0]  CH8_MAX         = 8'd255;

    typedef struct packed {
        logic [4:0] r;
        logic [4:0] g;
        logic [4:0] b;
    } t_rgb5;

    // Signed 16-bit coefficient k of a packed three-coefficient row.
    function automatic logic signed [15:0] coef(input logic [47:0] row,
                                                input logic [1:0] k);
        logic signed [15:0] c;
        case (k)
            2'd0:    c = row[15:0];
            2'd1:    c = row[31:16];
            default: c = row[47:32];
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/vertex_light_fog_shader.sv]
// Vertex light/fog shader.
// Input channel: i_valid / o_stall with the vertex fields (cmd, normal,
// prelit_value, depth); an item transfers on a clock edge with i_valid high
// and o_stall low. Output channel: o_valid / i_stall with o_color_rgb555.
// Registers are written over the APB port (8-byte stride, 64-bit data) and
// must only change while the pipeline holds no vertex.
// A vertex taken at the input passes the stage registers in order, and
// o_valid is the last stage's valid bit. Throughput is one vertex per
// cycle while the receiver does not stall, in the six-stage pipeline (two
// multiplier ranks for the lit path, one narrow multiplier rank for fog).
// Reset (synchronous, active low) empties the pipeline and restores the
// registers: fog_start to all ones, everything else to zero.
// When the receiver stalls, the output register holds its color and empty
// stages behind it keep filling; o_stall rises only once all six stages
// hold a vertex.
`default_nettype none

`include "vertex_light_fog_shader_defines.svh"

module vertex_light_fog_shader (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // APB register port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [vlfs_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [vlfs_pkg::DATA_W-1:0]       pwdata,
    output logic      [vlfs_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready,
    // vertex input
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_cmd,
    input  wire logic signed [15:0]                i_normal_x,
    input  wire logic signed [15:0]                i_normal_y,
    input  wire logic signed [15:0]                i_normal_z,
    input  wire logic [12:0]                       i_prelit_value,
    input  wire logic [30:0]                       i_depth,
    // color output
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [14:0]                            o_color_rgb555
);

    // ---------------- registers ----------------
    logic [23:0] r_ambient;
    logic [16:0] r_fog_start;
    logic [47:0] r_dir [3];
    logic [47:0] r_col [3];

    logic                 w_wr;
    vlfs_pkg::t_reg_idx   w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = vlfs_pkg::t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ambient   <= '0;
            r_fog_start <= vlfs_pkg::FOG_START_RESET;
            for (int i = 0; i < 3; i++) begin
                r_dir[i] <= '0;
                r_col[i] <= '0;
            end
        end else if (w_wr) begin
            unique case (w_idx)
                vlfs_pkg::REG_AMBIENT:   r_ambient   <= pwdata[23:0];
                vlfs_pkg::REG_FOG_START: r_fog_start <= pwdata[16:0];
                vlfs_pkg::REG_DIR0:      r_dir[0]    <= pwdata[47:0];
                vlfs_pkg::REG_DIR1:      r_dir[1]    <= pwdata[47:0];
                vlfs_pkg::REG_DIR2:      r_dir[2]    <= pwdata[47:0];
                vlfs_pkg::REG_COL_R:     r_col[0]    <= pwdata[47:0];
                vlfs_pkg::REG_COL_G:     r_col[1]    <= pwdata[47:0];
                vlfs_pkg::REG_COL_B:     r_col[2]    <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            vlfs_pkg::REG_AMBIENT:   prdata = {40'd0, r_ambient};
            vlfs_pkg::REG_FOG_START: prdata = {47'd0, r_fog_start};
            vlfs_pkg::REG_DIR0:      prdata = {16'd0, r_dir[0]};
            vlfs_pkg::REG_DIR1:      prdata = {16'd0, r_dir[1]};
            vlfs_pkg::REG_DIR2:      prdata = {16'd0, r_dir[2]};
            vlfs_pkg::REG_COL_R:     prdata = {16'd0, r_col[0]};
            vlfs_pkg::REG_COL_G:     prdata = {16'd0, r_col[1]};
            vlfs_pkg::REG_COL_B:     prdata = {16'd0, r_col[2]};
            default:                 prdata = '0;
        endcase
    end

    logic [7:0] w_amb [3];
    assign w_amb[0] = r_ambient[23:16];
    assign w_amb[1] = r_ambient[15:8];
    assign w_amb[2] = r_ambient[7:0];

    // ---------------- pipeline control ----------------
    // Each stage advances when it is empty or the one after it advances.
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_en6;

    assign w_en6   = !r6_v || !i_stall;
    assign w_en5   = !r5_v || w_en6;
    assign w_en4   = !r4_v || w_en5;
    assign w_en3   = !r3_v || w_en4;
    assign w_en2   = !r2_v || w_en3;
    assign w_en1   = !r1_v || w_en2;
    assign o_stall = !w_en1;
    assign o_valid = r6_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            if (w_en1) r1_v <= i_valid;
            if (w_en2) r2_v <= r1_v;
            if (w_en3) r3_v <= r2_v;
            if (w_en4) r4_v <= r3_v;
            if (w_en5) r5_v <= r4_v;
            if (w_en6) r6_v <= r5_v;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic               r1_cmd;
    logic signed [15:0] r1_n [3];
    logic [12:0]        r1_pv;
    logic [30:0]        r1_depth;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_cmd   <= i_cmd;
            r1_n[0]  <= i_normal_x;
            r1_n[1]  <= i_normal_y;
            r1_n[2]  <= i_normal_z;
            r1_pv    <= i_prelit_value;
            r1_depth <= i_depth;
        end
    end

    // ---------------- stage 2: normal products, shade, fog distance ----------------
    logic signed [31:0] n2_p [3][3];
    logic [12:0]        n2_inv;
    logic [7:0]         n2_shade;
    logic [30:0]        n2_fade;
    logic [30:0]        n2_diff;
    logic               n2_fog_on;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            for (int k = 0; k < 3; k++) begin
                n2_p[l][k] = vlfs_pkg::coef(r_dir[l], 2'(k)) * r1_n[k];
            end
        end
        n2_inv    = vlfs_pkg::PRELIT_MAX - r1_pv;
        n2_shade  = (n2_inv[12:5] == 8'd0) ? vlfs_pkg::SHADE_FULL : n2_inv[12:5];
        n2_fade   = {r_fog_start, 14'd0};
        n2_fog_on = r1_depth > n2_fade;
        n2_diff   = r1_depth - n2_fade;
    end

    logic               r2_cmd;
    logic signed [31:0] r2_p [3][3];
    logic [7:0]         r2_shade;
    logic               r2_fog_on;
    logic [14:0]        r2_fog_dist;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_cmd      <= r1_cmd;
            r2_p        <= n2_p;
            r2_shade    <= n2_shade;
            r2_fog_on   <= n2_fog_on;
            r2_fog_dist <= n2_diff[30:16];
        end
    end

    // ---------------- stage 3: light intensities, prelit color, fog factor ----------------
    logic signed [33:0] n3_sum [3];
    logic [16:0]        n3_i [3];
    logic [15:0]        n3_pp [3];
    logic [4:0]         n3_pre [3];
    logic [11:0]        n3_fval;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n3_sum[l] = {{2{r2_p[l][0][31]}}, r2_p[l][0]}
                      + {{2{r2_p[l][1][31]}}, r2_p[l][1]}
                      + {{2{r2_p[l][2][31]}}, r2_p[l][2]};
            // negative intensity clamps to zero
            n3_i[l]   = n3_sum[l][33] ? 17'd0 : n3_sum[l][32:16];
            // 255 * 255 >> 11 stays within 31, so no clamp is needed
            n3_pp[l]  = w_amb[l] * r2_shade;
            n3_pre[l] = n3_pp[l][15:11];
        end
        // zero stands for a non-positive factor
        if (r2_fog_dist >= 15'(vlfs_pkg::FOG_ONE)) begin
            n3_fval = 12'd0;
        end else begin
            n3_fval = vlfs_pkg::FOG_ONE - r2_fog_dist[11:0];
        end
    end

    logic        r3_cmd;
    logic [16:0] r3_i [3];
    logic [4:0]  r3_pre [3];
    logic        r3_fog_on;
    logic [11:0] r3_fval;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_cmd    <= r2_cmd;
            r3_i      <= n3_i;
            r3_pre    <= n3_pre;
            r3_fog_on <= r2_fog_on;
            r3_fval   <= n3_fval;
        end
    end

    // ---------------- stage 4: color mixing products ----------------
    logic signed [17:0] w_i_s [3];
    logic signed [33:0] n4_q [3][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_i_s[k] = {1'b0, r3_i[k]};
        end
        for (int l = 0; l < 3; l++) begin
            for (int k = 0; k < 3; k++) begin
                n4_q[l][k] = vlfs_pkg::coef(r_col[l], 2'(k)) * w_i_s[k];
            end
        end
    end

    logic               r4_cmd;
    logic signed [33:0] r4_q [3][3];
    logic [4:0]         r4_pre [3];
    logic               r4_fog_on;
    logic [11:0]        r4_fval;

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r4_cmd    <= r3_cmd;
            r4_q      <= n4_q;
            r4_pre    <= r3_pre;
            r4_fog_on <= r3_fog_on;
            r4_fval   <= r3_fval;
        end
    end

    // ---------------- stage 5: lit sum, ambient add, clamp, mode select ----------------
    logic signed [35:0] n5_sum [3];
    logic signed [20:0] n5_tot [3];
    logic [4:0]         n5_lit [3];
    vlfs_pkg::t_rgb5    n5_rgb;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n5_sum[l] = {{2{r4_q[l][0][33]}}, r4_q[l][0]}
                      + {{2{r4_q[l][1][33]}}, r4_q[l][1]}
                      + {{2{r4_q[l][2][33]}}, r4_q[l][2]};
            // upper bits of the sum are the floor shift by 16
            n5_tot[l] = {n5_sum[l][35], n5_sum[l][35:16]} + {13'd0, w_amb[l]};
            if (n5_tot[l][20]) begin
                n5_lit[l] = 5'd0;
            end else if (n5_tot[l][19:8] != 12'd0) begin
                n5_lit[l] = vlfs_pkg::CH8_MAX[7:3];
            end else begin
                n5_lit[l] = n5_tot[l][7:3];
            end
        end
        if (r4_cmd == vlfs_pkg::CMD_LIT) begin
            n5_rgb = '{r: n5_lit[0], g: n5_lit[1], b: n5_lit[2]};
        end else begin
            n5_rgb = '{r: r4_pre[0], g: r4_pre[1], b: r4_pre[2]};
        end
    end

    vlfs_pkg::t_rgb5 r5_rgb;
    logic            r5_fog_on;
    logic [11:0]     r5_fval;

    always_ff @(posedge i_clk) begin
        if (w_en5) begin
            r5_rgb    <= n5_rgb;
            r5_fog_on <= r4_fog_on;
            r5_fval   <= r4_fval;
        end
    end

    // ---------------- stage 6: fog attenuation, output register ----------------
    // (val * 8 * c) >> 14 == (val * c) >> 11; at most 2048 * 31, below 2^16
    logic [16:0]     n6_prod [3];
    logic [4:0]      w_ch [3];
    vlfs_pkg::t_rgb5 n6_rgb;

    assign w_ch[0] = r5_rgb.r;
    assign w_ch[1] = r5_rgb.g;
    assign w_ch[2] = r5_rgb.b;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n6_prod[l] = r5_fval * w_ch[l];
        end
        if (r5_fog_on) begin
            n6_rgb = '{r: n6_prod[0][15:11], g: n6_prod[1][15:11], b: n6_prod[2][15:11]};
        end else begin
            n6_rgb = r5_rgb;
        end
    end

    vlfs_pkg::t_rgb5 r_color;

    always_ff @(posedge i_clk) begin
        if (w_en6) begin
            r_color <= n6_rgb;
        end
    end

    assign o_color_rgb555 = r_color;

    // ---------------- assertions ----------------
    `VLFS_ASSERT_SAME(a_stall_only_when_full, i_clk, i_rst_n,
        o_stall, r1_v && r2_v && r3_v && r4_v && r5_v && r6_v,
        "input stalled while a pipeline stage is empty")

    `VLFS_ASSERT_NEXT(a_no_fog_passthrough, i_clk, i_rst_n,
        r5_v && w_en6 && !r5_fog_on, r_color == $past(r5_rgb),
        "color changed without fog")

    `VLFS_ASSERT_NEXT(a_full_fog_black, i_clk, i_rst_n,
        r5_v && w_en6 && r5_fog_on && (r5_fval == 12'd0), o_color_rgb555 == 15'd0,
        "fully fogged vertex not black")

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps

class vertex_color_board;
    localparam longint CH5_MAX = 31;

    logic [23:0] ambient;
    logic [16:0] fog_start;
    logic [47:0] dir_row [3];
    logic [47:0] col_row [3];   // red, green, blue weights
    logic [14:0] color_q [$];
    int unsigned errors;

    function new();
        ambient   = '0;
        fog_start = vlfs_pkg::FOG_START_RESET;
        for (int k = 0; k < 3; k++) begin
            dir_row[k] = '0;
            col_row[k] = '0;
        end
        errors = 0;
    endfunction

    // Wide bits above each register's width are dropped by the narrower fields.
    function void set_reg(vlfs_pkg::t_reg_idx idx, logic [63:0] value);
        case (idx)
            vlfs_pkg::REG_AMBIENT:   ambient    = value[23:0];
            vlfs_pkg::REG_FOG_START: fog_start  = value[16:0];
            vlfs_pkg::REG_DIR0:      dir_row[0] = value[47:0];
            vlfs_pkg::REG_DIR1:      dir_row[1] = value[47:0];
            vlfs_pkg::REG_DIR2:      dir_row[2] = value[47:0];
            vlfs_pkg::REG_COL_R:     col_row[0] = value[47:0];
            vlfs_pkg::REG_COL_G:     col_row[1] = value[47:0];
            vlfs_pkg::REG_COL_B:     col_row[2] = value[47:0];
            default: ;
        endcase
    endfunction

    function longint lane(logic [47:0] row, int k);
        logic [15:0] bits16;
        bits16 = row[16*k +: 16];
        return longint'($signed(bits16));
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Works out the color of one accepted vertex and queues it.
    function void note_vertex(logic cmd, logic signed [15:0] nx, logic signed [15:0] ny,
                              logic signed [15:0] nz, logic [12:0] prelit,
                              logic [30:0] depth);
        longint rgb [3];
        longint inten [3];
        longint amb, shade, dot, mix, fade, dz, fog_val;
        longint n [3];
        n[0] = longint'(nx);
        n[1] = longint'(ny);
        n[2] = longint'(nz);
        if (cmd == vlfs_pkg::CMD_PRELIT) begin
            shade = (longint'(vlfs_pkg::PRELIT_MAX) - longint'(prelit)) >> 5;
            if (shade == 0)
                shade = longint'(vlfs_pkg::SHADE_FULL);
            for (int ch = 0; ch < 3; ch++) begin
                amb = longint'(ambient[8*(2-ch) +: 8]);
                rgb[ch] = clamp((amb * shade) >>> 11, 0, CH5_MAX);
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                dot = lane(dir_row[k], 0) * n[0] + lane(dir_row[k], 1) * n[1] +
                      lane(dir_row[k], 2) * n[2];
                inten[k] = (dot < 0) ? 0 : (dot >>> 16);
            end
            for (int ch = 0; ch < 3; ch++) begin
                amb = longint'(ambient[8*(2-ch) +: 8]);
                mix = lane(col_row[ch], 0) * inten[0] + lane(col_row[ch], 1) * inten[1] +
                      lane(col_row[ch], 2) * inten[2];
                rgb[ch] = clamp(amb + (mix >>> 16), 0, longint'(vlfs_pkg::CH8_MAX)) >>> 3;
            end
        end
        fade = longint'(fog_start) << 14;
        dz = longint'(depth);
        if (dz > fade) begin
            fog_val = longint'(vlfs_pkg::FOG_ONE) - ((dz - fade) >>> 16);
            for (int ch = 0; ch < 3; ch++)
                rgb[ch] = (fog_val <= 0 || rgb[ch] <= 0) ? 0 : ((fog_val * 8 * rgb[ch]) >>> 14);
        end
        color_q.push_back({5'(rgb[0]), 5'(rgb[1]), 5'(rgb[2])});
    endfunction

    function void check_color(logic [14:0] got);
        logic [14:0] want;
        if (color_q.size() == 0) begin
            $error("color_rgb555: expected nothing, got %h", got);
            errors++;
        end else begin
            want = color_q.pop_front();
            if (got !== want) begin
                $error("color_rgb555: expected %h, got %h", want, got);
                errors++;
            end
        end
    endfunction

    function int pending();
        return color_q.size();
    endfunction
endclass

module tb_top;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 130;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [vlfs_pkg::ADDR_W-1:0]   paddr = '0;
    logic [vlfs_pkg::DATA_W-1:0]   pwdata = '0;
    logic [vlfs_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic                          i_cmd = 1'b0;
    logic signed [15:0]            i_normal_x = '0;
    logic signed [15:0]            i_normal_y = '0;
    logic signed [15:0]            i_normal_z = '0;
    logic [12:0]                   i_prelit_value = '0;
    logic [30:0]                   i_depth = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [14:0]                   o_color_rgb555;

    vertex_color_board shades;
    int vertices_in = 0;
    int colors_out = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    vertex_light_fog_shader DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_normal_x     (i_normal_x),
        .i_normal_y     (i_normal_y),
        .i_normal_z     (i_normal_z),
        .i_prelit_value (i_prelit_value),
        .i_depth        (i_depth),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_color_rgb555 (o_color_rgb555)
    );

    always #2 i_clk = ~i_clk;

    // Transfer monitor: predicts on input transfers, checks on output transfers.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                shades.note_vertex(i_cmd, i_normal_x, i_normal_y, i_normal_z,
                                   i_prelit_value, i_depth);
                vertices_in <= vertices_in + 1;
            end
            if (o_valid && !i_stall) begin
                shades.check_color(o_color_rgb555);
                colors_out <= colors_out + 1;
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                    (psel && penable && pwrite && pready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: one long hold-off to back up the pipe, a clean stretch, random stalls else.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && vertices_in >= 60) begin
            i_stall <= 1'b1;
            hold_left <= 60;
            hold_done <= 1'b1;
        end else if (colors_out >= 400 && colors_out < 550) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < 15);
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic write_reg(input vlfs_pkg::t_reg_idx idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shades.set_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [63:0] amb, input logic [63:0] fog,
                             input logic [63:0] d0, input logic [63:0] d1,
                             input logic [63:0] d2, input logic [63:0] cr,
                             input logic [63:0] cg, input logic [63:0] cb);
        write_reg(vlfs_pkg::REG_AMBIENT, amb);
        write_reg(vlfs_pkg::REG_FOG_START, fog);
        write_reg(vlfs_pkg::REG_DIR0, d0);
        write_reg(vlfs_pkg::REG_DIR1, d1);
        write_reg(vlfs_pkg::REG_DIR2, d2);
        write_reg(vlfs_pkg::REG_COL_R, cr);
        write_reg(vlfs_pkg::REG_COL_G, cg);
        write_reg(vlfs_pkg::REG_COL_B, cb);
    endtask

    task automatic push_vertex(input logic cmd, input logic [15:0] nx, input logic [15:0] ny,
                               input logic [15:0] nz, input logic [12:0] prelit,
                               input logic [30:0] depth);
        while (!(vertices_in >= 400 && vertices_in < 550) && $urandom_range(0, 99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_normal_x <= nx;
        i_normal_y <= ny;
        i_normal_z <= nz;
        i_prelit_value <= prelit;
        i_depth <= depth;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Wait out every queued color, then the pipeline depth, before touching registers.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (shades.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [47:0] rand_row(int span);
        logic [47:0] row;
        for (int k = 0; k < 3; k++)
            row[16*k +: 16] = 16'(int'($urandom_range(0, 2 * span)) - span);
        return row;
    endfunction

    // Depths cluster around the fog start so the attenuation ramp gets exercised.
    function automatic logic [30:0] rand_depth();
        longint fade, d;
        fade = longint'(shades.fog_start) << 14;
        case ($urandom_range(0, 3))
            0:       d = longint'($urandom) & 'h7FFF_FFFF;
            1:       d = fade - longint'($urandom_range(0, 1 << 20));
            default: d = fade + longint'($urandom_range(0, (2048 << 16) + (1 << 18)));
        endcase
        if (d < 0)
            d = 0;
        if (d > 'h7FFF_FFFF)
            d = 'h7FFF_FFFF;
        return 31'(d);
    endfunction

    task automatic configure_phase(input int phase);
        case (phase)
            1: load_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFE_0000,
                         64'hFFFF_7FFF_7FFF_7FFF, 64'hFFFF_7FFF_7FFF_7FFF,
                         64'hFFFF_7FFF_7FFF_7FFF, 64'hFFFF_7FFF_7FFF_7FFF,
                         64'hFFFF_7FFF_7FFF_7FFF, 64'hFFFF_7FFF_7FFF_7FFF);
            2: load_regs(64'h1234_5678_FF00_0000, 64'h0000_0000_0001_FFFF,
                         64'h0000_8000_8000_8000, 64'h0000_8000_8000_8000,
                         64'h0000_8000_8000_8000, 64'h0000_8000_8000_8000,
                         64'h0000_8000_8000_8000, 64'h0000_8000_8000_8000);
            3: load_regs(64'h0000_0000_00FF_FFFF, rand64(), rand64(), rand64(), rand64(),
                         {16'h0, rand_row(32767)}, {16'h0, rand_row(32767)},
                         {16'h0, rand_row(32767)});
            default: load_regs(rand64(), rand64(), rand64(), rand64(), rand64(),
                               {16'($urandom), rand_row(1024 << (phase % 2))},
                               {16'($urandom), rand_row(1024 << (phase % 2))},
                               {16'($urandom), rand_row(1024 << (phase % 2))});
        endcase
    endtask

    initial begin
        shades = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unit light directions, mixed-sign color weights, fog far away
        load_regs(64'hDEAD_0000_00FF_8040, 64'h0000_0000_0001_FFFF,
                  64'h0000_0000_0000_7FFF, 64'h0000_0000_7FFF_0000,
                  64'h0000_7FFF_0000_0000, 64'h0000_0000_0000_0400,
                  64'h0000_0000_0400_0000, 64'h0000_FC00_0000_0000);
        push_vertex(vlfs_pkg::CMD_PRELIT, 16'h7FFF, 16'h8000, 16'h0000, 13'd0, 31'd0);
        push_vertex(vlfs_pkg::CMD_PRELIT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 13'h1FFF,
                    31'd0);   // zero inverse, so full shade
        push_vertex(vlfs_pkg::CMD_PRELIT, 16'h0000, 16'h0000, 16'h0000, 13'd8160, 31'd5);
        push_vertex(vlfs_pkg::CMD_PRELIT, 16'h8000, 16'h8000, 16'h8000, 13'd8159, 31'd5);
        push_vertex(vlfs_pkg::CMD_PRELIT, 16'h1234, 16'h0000, 16'h0000, 13'd4096, 31'd100);
        push_vertex(vlfs_pkg::CMD_PRELIT, 16'h0000, 16'h0000, 16'h0000, 13'd31,
                    31'h7FFF_FFFF);
        push_vertex(vlfs_pkg::CMD_LIT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 13'h1FFF, 31'd0);
        push_vertex(vlfs_pkg::CMD_LIT, 16'h8000, 16'h8000, 16'h8000, 13'd0, 31'd0);
        push_vertex(vlfs_pkg::CMD_LIT, 16'h0000, 16'h0000, 16'h0000, 13'd0, 31'd0);
        push_vertex(vlfs_pkg::CMD_LIT, 16'h7FFF, 16'h0000, 16'h8000, 13'd77, 31'd0);
        push_vertex(vlfs_pkg::CMD_LIT, 16'h8000, 16'h7FFF, 16'h0000, 13'd0, 31'd1);
        push_vertex(vlfs_pkg::CMD_LIT, 16'h4000, 16'hC000, 16'h2000, 13'd0, 31'h7FFF_FFFF);
        push_vertex(vlfs_pkg::CMD_LIT, 16'h0001, 16'hFFFF, 16'h0001, 13'd0, 31'd0);
        settle();

        // fog from depth zero: walk the attenuation factor through its end points
        load_regs(64'h0000_0000_00FF_FFFF, 64'hFFFF_FFFF_FFFE_0000,
                  64'h0000_0000_0000_7FFF, 64'h0000_0000_7FFF_0000,
                  64'h0000_7FFF_0000_0000, 64'h0000_0000_0000_0400,
                  64'h0000_0000_0400_0000, 64'h0000_0400_0000_0000);
        push_vertex(vlfs_pkg::CMD_PRELIT, 16'h0000, 16'h0000, 16'h0000, 13'd0, 31'd0);
        push_vertex(vlfs_pkg::CMD_PRELIT, 16'h0000, 16'h0000, 16'h0000, 13'd0, 31'd1);
        push_vertex(vlfs_pkg::CMD_PRELIT, 16'h0000, 16'h0000, 16'h0000, 13'd0,
                    31'd1024 << 16);
        push_vertex(vlfs_pkg::CMD_PRELIT, 16'h0000, 16'h0000, 16'h0000, 13'd0,
                    31'd2047 << 16);
        push_vertex(vlfs_pkg::CMD_PRELIT, 16'h0000, 16'h0000, 16'h0000, 13'd0,
                    31'd2048 << 16);
        push_vertex(vlfs_pkg::CMD_PRELIT, 16'h0000, 16'h0000, 16'h0000, 13'd0,
                    31'h7FFF_FFFF);
        push_vertex(vlfs_pkg::CMD_LIT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 13'd0,
                    (31'd2047 << 16) + 31'd5);
        push_vertex(vlfs_pkg::CMD_LIT, 16'h0000, 16'h0000, 16'h0000, 13'd0,
                    31'd1024 << 16);
        push_vertex(vlfs_pkg::CMD_PRELIT, 16'h0000, 16'h0000, 16'h0000, 13'h1FFF,
                    31'h7FFF_FFFF);
        settle();

        for (int phase = 0; phase < 6; phase++) begin
            configure_phase(phase);
            repeat (PHASE_ITEMS)
                push_vertex(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                            16'($urandom), 13'($urandom_range(0, 8191)), rand_depth());
            settle();
        end

        if (shades.errors == 0 && shades.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[files.f]
+incdir+hdl
hdl/vlfs_pkg.sv
hdl/vertex_light_fog_shader.sv
sim/tb_top.sv
